// File: hw/rtl/srtf_pkg.sv
// Package with the shared types, constants and helpers of the SRTF job scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = 4;
    localparam int SLOTS_DEF = 16;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] arrival_time;
        logic [TIME_BITS-1:0] burst_length;
    } in_item_t;

    typedef struct packed {
        logic                 ran;
        logic [SLOT_BITS-1:0] ran_slot;
        logic                 finished;
        logic [TIME_BITS-1:0] done_time;
        logic [TIME_BITS-1:0] turnaround;
        logic [TIME_BITS-1:0] wait_time;
        logic [TIME_BITS-1:0] time_now;
    } out_item_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic live;
    } sel_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == TIME_MAX) ? TIME_MAX : v + 1'b1;
    endfunction

endpackage

// File: hw/rtl/srtf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module srtf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/srtf_sel.sv
// Shared compare unit that keeps the best candidate seen during a slot scan.
`timescale 1ns / 1ps

module srtf_sel #(
    parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  srtf_pkg::sel_ctrl_t                 ctrl,
    input  logic [$clog2(SLOTS)-1:0]            rd_slot,
    input  srtf_pkg::entry_t                    rd_entry,
    input  logic [srtf_pkg::TIME_BITS-1:0]      tick,
    output logic                                best_have,
    output logic [$clog2(SLOTS)-1:0]            best_slot,
    output srtf_pkg::entry_t                    best_entry
);

    localparam int IDX_W = $clog2(SLOTS);

    logic             have_reg, have_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    srtf_pkg::entry_t entry_reg, entry_next;
    logic             cand;
    logic             take;

    always_comb begin
        cand = ctrl.sample && ctrl.live && (rd_entry.remaining != '0) &&
               (rd_entry.arrival <= tick);
        take = cand && (!have_reg || (rd_entry.remaining < entry_reg.remaining));
        have_next  = have_reg;
        slot_next  = slot_reg;
        entry_next = entry_reg;
        if (ctrl.clear) begin
            have_next = 1'b0;
        end else if (take) begin
            have_next  = 1'b1;
            slot_next  = rd_slot;
            entry_next = rd_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else begin
            have_reg <= have_next;
        end
        slot_reg  <= slot_next;
        entry_reg <= entry_next;
    end

    assign best_have  = have_reg;
    assign best_slot  = slot_reg;
    assign best_entry = entry_reg;

endmodule

// File: hw/rtl/srtf_job_scheduler.sv
// Top level of the SRTF job scheduler: sequencer, slot table, tick counter and result register.
// A load item writes its slot and goes to the result state; the next item is accepted once its
// result has been handed to the output register, which can wait on m_ready.
// A tick item scans the incumbent and then every slot through one compare unit, one RAM read
// per cycle, then updates the chosen slot and hands its result to the output register; the next
// item is accepted only after that. The single slot RAM read port is why the slots are read one by one.
// Reset clears the tick counter, the slot valid bits and the incumbent.
`timescale 1ns / 1ps

module srtf_job_scheduler #(
    parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srtf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srtf_pkg::out_item_t m_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 2);
    localparam int TB    = srtf_pkg::TIME_BITS;

    srtf_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TB-1:0]       tick_reg, tick_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]    run_slot_reg, run_slot_next;
    logic                run_valid_reg, run_valid_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                rd_first_reg, rd_first_next;
    logic [IDX_W-1:0]    rd_slot_reg, rd_slot_next;
    srtf_pkg::out_item_t res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    srtf_pkg::out_item_t m_data_reg, m_data_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    srtf_pkg::entry_t    ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [$bits(srtf_pkg::entry_t)-1:0] ram_rdata;

    srtf_pkg::sel_ctrl_t sel_ctrl;
    logic                best_have;
    logic [IDX_W-1:0]    best_slot;
    srtf_pkg::entry_t    best_entry;

    logic                accept;
    logic                in_range;
    logic [TB-1:0]       new_rem;
    logic [TB-1:0]       done_t;
    logic [TB-1:0]       turn_t;
    logic                fin;

    srtf_ram #(
        .WIDTH($bits(srtf_pkg::entry_t)),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srtf_sel #(
        .SLOTS(SLOTS)
    ) u_sel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (sel_ctrl),
        .rd_slot    (rd_slot_reg),
        .rd_entry   (srtf_pkg::entry_t'(ram_rdata)),
        .tick       (tick_reg),
        .best_have  (best_have),
        .best_slot  (best_slot),
        .best_entry (best_entry)
    );

    assign s_ready = (state_reg == srtf_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tick_next      = tick_reg;
        valid_next     = valid_reg;
        run_slot_next  = run_slot_reg;
        run_valid_next = run_valid_reg;
        rd_vld_next    = 1'b0;
        rd_first_next  = 1'b0;
        rd_slot_next   = rd_slot_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = IDX_W'(s_data.slot);
        ram_wdata = '{arrival: s_data.arrival_time, burst: s_data.burst_length,
                      remaining: s_data.burst_length};
        ram_re    = 1'b0;
        ram_raddr = run_slot_reg;

        sel_ctrl.clear  = 1'b0;
        sel_ctrl.sample = rd_vld_reg;
        sel_ctrl.live   = valid_reg[rd_slot_reg] && (!rd_first_reg || run_valid_reg);

        in_range = (32'(s_data.slot) < 32'(SLOTS));
        new_rem  = best_entry.remaining - 1'b1;
        fin      = (new_rem == '0);
        done_t   = srtf_pkg::sat_inc(tick_reg);
        turn_t   = (done_t >= best_entry.arrival) ? done_t - best_entry.arrival : '0;

        unique case (state_reg)
            srtf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.action == srtf_pkg::ACT_LOAD) begin
                        ram_we = in_range;
                        if (in_range) begin
                            valid_next[IDX_W'(s_data.slot)] = 1'b1;
                        end
                        res_next          = '0;
                        res_next.time_now = tick_reg;
                        state_next        = srtf_pkg::ST_RESP;
                    end else begin
                        sel_ctrl.clear = 1'b1;
                        cnt_next       = '0;
                        state_next     = srtf_pkg::ST_SCAN;
                    end
                end
            end
            srtf_pkg::ST_SCAN: begin
                if (32'(cnt_reg) <= 32'(SLOTS)) begin
                    ram_re        = 1'b1;
                    ram_raddr     = (cnt_reg == '0) ? run_slot_reg : IDX_W'(cnt_reg - 1'b1);
                    rd_vld_next   = 1'b1;
                    rd_first_next = (cnt_reg == '0);
                    rd_slot_next  = ram_raddr;
                    cnt_next      = cnt_reg + 1'b1;
                end else begin
                    state_next = srtf_pkg::ST_UPDATE;
                end
            end
            srtf_pkg::ST_UPDATE: begin
                res_next          = '0;
                res_next.time_now = done_t;
                tick_next         = done_t;
                run_valid_next    = 1'b0;
                if (best_have) begin
                    ram_we            = 1'b1;
                    ram_waddr         = best_slot;
                    ram_wdata         = '{arrival: best_entry.arrival, burst: best_entry.burst,
                                          remaining: new_rem};
                    res_next.ran      = 1'b1;
                    res_next.ran_slot = srtf_pkg::SLOT_BITS'(best_slot);
                    if (fin) begin
                        res_next.finished   = 1'b1;
                        res_next.done_time  = done_t;
                        res_next.turnaround = turn_t;
                        res_next.wait_time  = (turn_t > best_entry.burst) ?
                                              turn_t - best_entry.burst : '0;
                    end else begin
                        run_valid_next = 1'b1;
                        run_slot_next  = best_slot;
                    end
                end
                state_next = srtf_pkg::ST_RESP;
            end
            srtf_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = srtf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srtf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            valid_reg     <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            valid_reg     <= valid_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            rd_vld_reg    <= rd_vld_next;
            rd_first_reg  <= rd_first_next;
            m_valid_reg   <= m_valid_next;
        end
        rd_slot_reg <= rd_slot_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// File: sim/tb_srtf_job_scheduler.sv
// Self-checking testbench of the SRTF job scheduler, predicting every result transfer.
`timescale 1ns / 1ps

module tb_srtf_job_scheduler;

    localparam int NSLOTS = 16;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    srtf_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    srtf_pkg::out_item_t m_data;

    srtf_job_scheduler #(.SLOTS(NSLOTS)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    srtf_pkg::in_item_t  job_stream[$];
    srtf_pkg::out_item_t pending_outcomes[$];
    srtf_pkg::out_item_t want_res;
    srtf_pkg::out_item_t got_res;

    logic [srtf_pkg::TIME_BITS-1:0] job_arrival [NSLOTS];
    logic [srtf_pkg::TIME_BITS-1:0] job_burst [NSLOTS];
    logic [srtf_pkg::TIME_BITS-1:0] job_left [NSLOTS];
    logic [srtf_pkg::TIME_BITS-1:0] sched_clock = '0;
    logic [srtf_pkg::SLOT_BITS-1:0] inc_slot = '0;
    logic                           inc_valid = 1'b0;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   plan_tick = 0;
    logic in_taken = 1'b0;
    int   mismatches = 0;
    int   n_checked = 0;
    int   n_load_items = 0;
    int   n_tick_items = 0;
    int   n_completions = 0;
    int   n_preemptions = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("** srtf_job_scheduler: FAILED **");
        $finish;
    end

    function automatic logic eligible(input int s);
        return job_left[s] != '0 && job_arrival[s] <= sched_clock;
    endfunction

    function automatic srtf_pkg::out_item_t run_scheduler_step(input srtf_pkg::in_item_t it);
        srtf_pkg::out_item_t            r;
        logic                           have;
        logic                           inc_live;
        logic [srtf_pkg::SLOT_BITS-1:0] pick;
        logic [srtf_pkg::TIME_BITS-1:0] done;
        logic [srtf_pkg::TIME_BITS-1:0] turn;
        r = '0;
        if (it.action == srtf_pkg::ACT_LOAD) begin
            job_arrival[it.slot] = it.arrival_time;
            job_burst[it.slot] = it.burst_length;
            job_left[it.slot] = it.burst_length;
            n_load_items++;
        end else begin
            inc_live = inc_valid && eligible(inc_slot);
            have = inc_live;
            pick = inc_live ? inc_slot : '0;
            for (int j = 0; j < NSLOTS; j++) begin
                if (eligible(j) && (!have || job_left[j] < job_left[pick])) begin
                    have = 1'b1;
                    pick = srtf_pkg::SLOT_BITS'(j);
                end
            end
            if (have) begin
                if (inc_live && pick != inc_slot) n_preemptions++;
                r.ran = 1'b1;
                r.ran_slot = pick;
                job_left[pick] = job_left[pick] - 1'b1;
                if (job_left[pick] == '0) begin
                    done = (sched_clock == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX :
                           sched_clock + 1'b1;
                    turn = (done >= job_arrival[pick]) ? done - job_arrival[pick] : '0;
                    r.finished = 1'b1;
                    r.done_time = done;
                    r.turnaround = turn;
                    r.wait_time = (turn > job_burst[pick]) ? turn - job_burst[pick] : '0;
                    inc_valid = 1'b0;
                    n_completions++;
                end else begin
                    inc_valid = 1'b1;
                    inc_slot = pick;
                end
            end else begin
                inc_valid = 1'b0;
            end
            sched_clock = (sched_clock == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX :
                          sched_clock + 1'b1;
            n_tick_items++;
        end
        r.time_now = sched_clock;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (job_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= job_stream.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) pending_outcomes.push_back(run_scheduler_step(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no result outstanding");
                mismatches++;
            end else begin
                want_res = pending_outcomes.pop_front();
                got_res = m_data;
                check_field("ran", want_res.ran, got_res.ran);
                check_field("ran_slot", want_res.ran_slot, got_res.ran_slot);
                check_field("finished", want_res.finished, got_res.finished);
                check_field("done_time", want_res.done_time, got_res.done_time);
                check_field("turnaround", want_res.turnaround, got_res.turnaround);
                check_field("wait_time", want_res.wait_time, got_res.wait_time);
                check_field("time_now", want_res.time_now, got_res.time_now);
                n_checked++;
            end
        end
    end

    task automatic push_load(input int s, input int a, input int b);
        srtf_pkg::in_item_t it;
        it = '0;
        it.action = srtf_pkg::ACT_LOAD;
        it.slot = srtf_pkg::SLOT_BITS'(s);
        it.arrival_time = srtf_pkg::TIME_BITS'(a);
        it.burst_length = srtf_pkg::TIME_BITS'(b);
        job_stream.push_back(it);
    endtask

    task automatic push_tick();
        srtf_pkg::in_item_t it;
        it = '0;
        it.action = srtf_pkg::ACT_TICK;
        it.slot = srtf_pkg::SLOT_BITS'($urandom_range(NSLOTS - 1));
        it.arrival_time = srtf_pkg::TIME_BITS'($urandom_range(16'hFFFF));
        it.burst_length = srtf_pkg::TIME_BITS'($urandom_range(16'hFFFF));
        job_stream.push_back(it);
        if (plan_tick < int'(srtf_pkg::TIME_MAX)) plan_tick++;
    endtask

    // Mostly short batches of jobs arriving soon followed by a few ticks, with some
    // far-future or huge jobs and slot clears mixed in.
    task automatic add_random_items(input int count);
        int target;
        int r;
        target = job_stream.size() + count;
        while (job_stream.size() < target) begin
            r = $urandom_range(99);
            if (r < 12) begin
                push_load($urandom_range(NSLOTS - 1), $urandom_range(16'hFFFF),
                          $urandom_range(16'hFFFF));
            end else if (r < 17) begin
                push_load($urandom_range(NSLOTS - 1), $urandom_range(16'hFFFF), 0);
            end else begin
                repeat ($urandom_range(1, 3))
                    push_load($urandom_range(NSLOTS - 1), plan_tick + $urandom_range(5),
                              $urandom_range(1, 6));
                repeat ($urandom_range(1, 8)) push_tick();
            end
        end
    endtask

    task automatic wait_idle();
        while (job_stream.size() != 0 || s_valid || pending_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int k = 0; k < NSLOTS; k++) begin
            job_arrival[k] = '0;
            job_burst[k] = '0;
            job_left[k] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 7;
        rx_stall_pct = 70;
        push_tick();
        push_load(0, 0, 0);
        push_load(15, 0, 3);
        push_load(3, 0, 3);
        push_tick();
        push_load(7, 0, 2);
        push_tick();
        push_load(5, 0, 1);
        push_tick();
        push_load(7, 16'hFFFF, 16'hFFFF);
        push_load(9, 4, 5);
        push_tick();
        push_tick();
        push_load(15, 10, 4);
        push_tick();
        push_load(9, 0, 1);
        push_tick();
        push_load(2, 0, 6);
        push_tick();
        push_load(4, 0, 2);
        push_tick();
        push_tick();
        push_tick();
        add_random_items(375);
        wait_idle();

        tx_idle_pct = 70;
        rx_stall_pct = 7;
        add_random_items(375);
        wait_idle();

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        add_random_items(375);
        wait_idle();
        repeat (NSLOTS + 10) @(posedge aclk);

        $display("Covered %0d load and %0d tick transfers: %0d jobs completed, %0d preemptions.",
                 n_load_items, n_tick_items, n_completions, n_preemptions);
        $display("Checked %0d results, %0d mismatches, final tick counter %0d.",
                 n_checked, mismatches, sched_clock);
        if (mismatches == 0) begin
            $display("** srtf_job_scheduler: PASSED **");
        end else begin
            $display("** srtf_job_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
